// ----- rtl/core/multi_click_and_motion_tracker_core_macros.svh -----
// Assertion helpers shared by the tracker core files.
`ifndef MULTI_CLICK_AND_MOTION_TRACKER_CORE_MACROS_SVH
`define MULTI_CLICK_AND_MOTION_TRACKER_CORE_MACROS_SVH
`ifndef SYNTH
// Check prop at every rising edge outside of reset.
`define MCMT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mcmt: assertion failed");
// Check prop at every rising edge, reset included.
`define MCMT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("mcmt: assertion failed");
`else
`define MCMT_ASSERT(label, clk, rst_n, prop)
`define MCMT_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- rtl/core/mcmt_pkg.sv -----
`default_nettype none

package mcmt_pkg;

    localparam int COORD_BITS    = 16;
    localparam int TIME_BITS     = 32;
    localparam int DELTA_BITS    = COORD_BITS + 1;
    localparam int KIND_BITS     = 3;
    localparam int BUTTON_BITS   = 3;
    localparam int OKIND_BITS    = 2;
    localparam int CLICK_BITS    = 3;
    localparam int INTERVAL_BITS = 16;
    localparam int SLOP_BITS     = 10;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 2;
    localparam int OP_BITS       = 3;
    // Width that holds both a widget-space difference and the signed slop.
    localparam int SPAN_BITS     = (DELTA_BITS > SLOP_BITS + 1) ? DELTA_BITS : SLOP_BITS + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DELTA_BITS-1:0] t_delta;
    typedef logic [TIME_BITS-1:0]         t_time;
    typedef logic [KIND_BITS-1:0]         t_kind;
    typedef logic [BUTTON_BITS-1:0]       t_button;
    typedef logic [OKIND_BITS-1:0]        t_okind;
    typedef logic [CLICK_BITS-1:0]        t_clicks;
    typedef logic [OP_BITS-1:0]           t_opcode;

    // Event kinds on the input channel
    localparam t_kind KIND_MOVE    = 3'd0;
    localparam t_kind KIND_PRESS   = 3'd1;
    localparam t_kind KIND_RELEASE = 3'd2;
    localparam t_kind KIND_ENTER   = 3'd3;
    localparam t_kind KIND_LEAVE   = 3'd4;
    localparam t_kind KIND_OTHER   = 3'd5;
    localparam t_kind KIND_CLEAR   = 3'd6;
    localparam t_kind KIND_UNUSED  = 3'd7;

    // Operations queued between front and back
    localparam t_opcode OP_MOVE    = 3'd0;
    localparam t_opcode OP_PRESS   = 3'd1;
    localparam t_opcode OP_RELEASE = 3'd2;
    localparam t_opcode OP_LEAVE   = 3'd3;
    localparam t_opcode OP_OTHER   = 3'd4;
    localparam t_opcode OP_CLEAR   = 3'd5;

    // Result kinds
    localparam t_okind OKIND_MOVE    = 2'd0;
    localparam t_okind OKIND_PRESS   = 2'd1;
    localparam t_okind OKIND_RELEASE = 2'd2;
    localparam t_okind OKIND_OTHER   = 2'd3;

    localparam t_button BUTTON_NONE = 3'd0;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SLOP     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_MAX      = 2'd2;

    localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = INTERVAL_BITS'(500);
    localparam logic [SLOP_BITS-1:0]     SLOP_RESET     = SLOP_BITS'(25);
    localparam t_clicks                  MAX_RESET      = CLICK_BITS'(3);

    typedef struct packed {
        logic [INTERVAL_BITS-1:0] interval;
        logic [SLOP_BITS-1:0]     slop;
        t_clicks                  max_clicks;
    } t_cfg;

    typedef struct packed {
        t_opcode op;
        t_button button;
        t_coord  screen_x;
        t_coord  screen_y;
        t_coord  widget_x;
        t_coord  widget_y;
        t_time   time_ms;
    } t_op;

endpackage

`default_nettype wire

// ----- rtl/core/mcmt_evt_if.sv -----
`default_nettype none

interface mcmt_evt_if;
    logic                valid;
    logic                ready;
    mcmt_pkg::t_kind     event_kind;
    mcmt_pkg::t_button   button;
    mcmt_pkg::t_coord    screen_x;
    mcmt_pkg::t_coord    screen_y;
    mcmt_pkg::t_coord    widget_x;
    mcmt_pkg::t_coord    widget_y;
    mcmt_pkg::t_time     time_ms;

    modport source (
        output valid, event_kind, button, screen_x, screen_y, widget_x, widget_y, time_ms,
        input  ready
    );
    modport sink (
        input  valid, event_kind, button, screen_x, screen_y, widget_x, widget_y, time_ms,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/mcmt_res_if.sv -----
`default_nettype none

interface mcmt_res_if;
    logic               valid;
    logic               ready;
    mcmt_pkg::t_okind   out_kind;
    mcmt_pkg::t_delta   delta_x;
    mcmt_pkg::t_delta   delta_y;
    mcmt_pkg::t_clicks  clicks;

    modport source (
        output valid, out_kind, delta_x, delta_y, clicks,
        input  ready
    );
    modport sink (
        input  valid, out_kind, delta_x, delta_y, clicks,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/core/mcmt_front.sv -----
`default_nettype none
`include "multi_click_and_motion_tracker_core_macros.svh"

// Accept events, turn them into queued operations, drop the unused kind.
module mcmt_front (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    mcmt_evt_if.sink      i_evt,
    input  wire logic     i_pop,
    output logic          o_q_valid,
    output mcmt_pkg::t_op o_q_op
);

    mcmt_pkg::t_op                     r_mem [mcmt_pkg::QUEUE_DEPTH];
    logic [mcmt_pkg::QPTR_BITS-1:0]    r_wr_ptr, n_wr_ptr;
    logic [mcmt_pkg::QPTR_BITS-1:0]    r_rd_ptr, n_rd_ptr;
    logic [mcmt_pkg::QCNT_BITS-1:0]    r_count, n_count;
    mcmt_pkg::t_opcode                 w_opcode;
    logic                              w_keep;
    logic                              w_accept;
    logic                              w_push;
    mcmt_pkg::t_op                     w_entry;

    always_comb begin
        w_keep   = 1'b1;
        w_opcode = mcmt_pkg::OP_MOVE;
        case (i_evt.event_kind)
            mcmt_pkg::KIND_MOVE:    w_opcode = mcmt_pkg::OP_MOVE;
            mcmt_pkg::KIND_ENTER:   w_opcode = mcmt_pkg::OP_MOVE;
            mcmt_pkg::KIND_PRESS:   w_opcode = mcmt_pkg::OP_PRESS;
            mcmt_pkg::KIND_RELEASE: w_opcode = mcmt_pkg::OP_RELEASE;
            mcmt_pkg::KIND_LEAVE:   w_opcode = mcmt_pkg::OP_LEAVE;
            mcmt_pkg::KIND_OTHER:   w_opcode = mcmt_pkg::OP_OTHER;
            mcmt_pkg::KIND_CLEAR:   w_opcode = mcmt_pkg::OP_CLEAR;
            default:                w_keep   = 1'b0;
        endcase
    end

    always_comb begin
        w_entry.op       = w_opcode;
        w_entry.button   = i_evt.button;
        w_entry.screen_x = i_evt.screen_x;
        w_entry.screen_y = i_evt.screen_y;
        w_entry.widget_x = i_evt.widget_x;
        w_entry.widget_y = i_evt.widget_y;
        w_entry.time_ms  = i_evt.time_ms;
    end

    assign i_evt.ready = (r_count != mcmt_pkg::QCNT_BITS'(mcmt_pkg::QUEUE_DEPTH));
    assign w_accept    = i_evt.valid && i_evt.ready;
    assign w_push      = w_accept && w_keep;

    assign o_q_valid = (r_count != '0);
    assign o_q_op    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == mcmt_pkg::QPTR_BITS'(mcmt_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == mcmt_pkg::QPTR_BITS'(mcmt_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        case ({w_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_entry;
        end
    end

    `MCMT_ASSERT_ALWAYS(a_reset_empties_queue, i_clk, !i_rst_n |=> r_count == '0)
    `MCMT_ASSERT(a_unused_kind_dropped, i_clk, i_rst_n, (w_accept && i_evt.event_kind == mcmt_pkg::KIND_UNUSED) |-> !w_push)
    `MCMT_ASSERT(a_push_into_empty_shows, i_clk, i_rst_n, (r_count == '0 && w_push) |=> o_q_valid)

endmodule

`default_nettype wire

// ----- rtl/core/mcmt_back.sv -----
`default_nettype none
`include "multi_click_and_motion_tracker_core_macros.svh"

// Carry out queued operations: pointer tracking, click runs, result register.
module mcmt_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mcmt_pkg::t_cfg i_cfg,
    input  wire logic          i_q_valid,
    input  wire mcmt_pkg::t_op i_q_op,
    output logic               o_pop,
    mcmt_res_if.source         o_res
);

    logic                   r_inside;
    mcmt_pkg::t_coord       r_last_x;
    mcmt_pkg::t_coord       r_last_y;
    mcmt_pkg::t_clicks      r_run_count;
    mcmt_pkg::t_button      r_run_button;
    mcmt_pkg::t_coord       r_run_x;
    mcmt_pkg::t_coord       r_run_y;
    mcmt_pkg::t_time        r_run_time;

    logic                   r_out_valid, n_out_valid;
    mcmt_pkg::t_okind       r_out_kind;
    mcmt_pkg::t_delta       r_out_dx;
    mcmt_pkg::t_delta       r_out_dy;
    mcmt_pkg::t_clicks      r_out_clicks;

    logic                   w_is_clear, w_is_press, w_is_leave;
    logic                   w_first;
    mcmt_pkg::t_coord       w_base_x, w_base_y;
    mcmt_pkg::t_delta       w_dx, w_dy;
    mcmt_pkg::t_time        w_gap;
    logic                   w_gap_ok;
    logic signed [mcmt_pkg::SPAN_BITS-1:0] w_wdx, w_wdy, w_slop;
    logic                   w_near_x, w_near_y;
    logic                   w_same;
    mcmt_pkg::t_clicks      w_new_count;
    mcmt_pkg::t_okind       w_kind;

    assign w_is_clear = (i_q_op.op == mcmt_pkg::OP_CLEAR);
    assign w_is_press = (i_q_op.op == mcmt_pkg::OP_PRESS);
    assign w_is_leave = (i_q_op.op == mcmt_pkg::OP_LEAVE);

    // A clear gives no result, so it may retire while the result register is held.
    assign o_pop = i_q_valid && (w_is_clear || !r_out_valid || o_res.ready);

    // Motion: the first event after entry measures against itself.
    assign w_first  = !w_is_leave && !r_inside;
    assign w_base_x = w_first ? i_q_op.screen_x : r_last_x;
    assign w_base_y = w_first ? i_q_op.screen_y : r_last_y;
    assign w_dx = {i_q_op.screen_x[mcmt_pkg::COORD_BITS-1], i_q_op.screen_x}
                - {w_base_x[mcmt_pkg::COORD_BITS-1], w_base_x};
    assign w_dy = {i_q_op.screen_y[mcmt_pkg::COORD_BITS-1], i_q_op.screen_y}
                - {w_base_y[mcmt_pkg::COORD_BITS-1], w_base_y};

    // Click run match
    assign w_gap    = i_q_op.time_ms - r_run_time;
    assign w_gap_ok = (w_gap <= {{(mcmt_pkg::TIME_BITS - mcmt_pkg::INTERVAL_BITS){1'b0}},
                                 i_cfg.interval});
    assign w_wdx  = mcmt_pkg::SPAN_BITS'(i_q_op.widget_x) - mcmt_pkg::SPAN_BITS'(r_run_x);
    assign w_wdy  = mcmt_pkg::SPAN_BITS'(i_q_op.widget_y) - mcmt_pkg::SPAN_BITS'(r_run_y);
    assign w_slop = {{(mcmt_pkg::SPAN_BITS - mcmt_pkg::SLOP_BITS){1'b0}}, i_cfg.slop};
    assign w_near_x = (w_wdx <= w_slop) && (w_wdx >= -w_slop);
    assign w_near_y = (w_wdy <= w_slop) && (w_wdy >= -w_slop);
    assign w_same = (r_run_count != '0) && (r_run_count < i_cfg.max_clicks)
                 && (i_q_op.button == r_run_button) && w_gap_ok && w_near_x && w_near_y;
    assign w_new_count = w_same ? r_run_count + 1'b1 : mcmt_pkg::CLICK_BITS'(1);

    always_comb begin
        case (i_q_op.op)
            mcmt_pkg::OP_PRESS:   w_kind = mcmt_pkg::OKIND_PRESS;
            mcmt_pkg::OP_RELEASE: w_kind = mcmt_pkg::OKIND_RELEASE;
            mcmt_pkg::OP_OTHER:   w_kind = mcmt_pkg::OKIND_OTHER;
            default:              w_kind = mcmt_pkg::OKIND_MOVE;
        endcase
    end

    assign n_out_valid = (r_out_valid && !o_res.ready) || (o_pop && !w_is_clear);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside     <= 1'b0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_run_count  <= '0;
            r_run_button <= mcmt_pkg::BUTTON_NONE;
            r_run_x      <= '0;
            r_run_y      <= '0;
            r_run_time   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_pop) begin
                if (w_is_clear) begin
                    r_run_count  <= '0;
                    r_run_button <= mcmt_pkg::BUTTON_NONE;
                    r_run_x      <= '0;
                    r_run_y      <= '0;
                    r_run_time   <= '0;
                end else begin
                    r_inside <= !w_is_leave;
                    r_last_x <= i_q_op.screen_x;
                    r_last_y <= i_q_op.screen_y;
                    if (w_is_press) begin
                        r_run_count <= w_new_count;
                        r_run_time  <= i_q_op.time_ms;
                        if (!w_same) begin
                            r_run_button <= i_q_op.button;
                            r_run_x      <= i_q_op.widget_x;
                            r_run_y      <= i_q_op.widget_y;
                        end
                    end
                end
            end
        end
    end

    // Result payload: load on a retiring non-clear operation.
    always_ff @(posedge i_clk) begin
        if (o_pop && !w_is_clear) begin
            r_out_kind   <= w_kind;
            r_out_dx     <= w_dx;
            r_out_dy     <= w_dy;
            r_out_clicks <= w_is_press ? w_new_count : '0;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.out_kind = r_out_kind;
    assign o_res.delta_x  = r_out_dx;
    assign o_res.delta_y  = r_out_dy;
    assign o_res.clicks   = r_out_clicks;

    `MCMT_ASSERT(a_clicks_only_on_press, i_clk, i_rst_n, r_out_valid |-> ((r_out_kind == mcmt_pkg::OKIND_PRESS) == (r_out_clicks != '0)))
    `MCMT_ASSERT(a_clear_empties_run, i_clk, i_rst_n, (o_pop && w_is_clear) |=> (r_run_count == '0 && r_run_button == mcmt_pkg::BUTTON_NONE))
    `MCMT_ASSERT(a_leave_drops_inside, i_clk, i_rst_n, (o_pop && w_is_leave) |=> !r_inside)

endmodule

`default_nettype wire

// ----- rtl/core/multi_click_and_motion_tracker_core.sv -----
// Pointer event tracker: screen-space motion deltas and multi-click counting.
// Input channel i_evt carries one pointer event per beat (kind, button, screen
// and widget position, millisecond timestamp); output channel o_res carries one
// result beat per event: result kind, screen delta x/y and click count.
// Clear-history beats and the unused kind are consumed without a result.
// Path: a beat accepted on i_evt is written into the queue, then retired by
// the back end into the result register that drives o_res, when the output
// is free. Throughput: one event per clock while o_res is not stalled, set by
// the back-end state update; the front end feeds it from a 4-entry queue.
// Configuration: i_cfg_we writes register i_cfg_idx (0 click interval,
// 1 slop, 2 max clicks) from i_cfg_data; write only while the block is idle.
// Reset (synchronous, i_rst_n low): queue and result register empty, pointer
// outside, click run cleared, registers back to 500 ms, 25 px, 3 clicks.
// Backpressure: a stalled o_res holds its beat; the queue keeps taking events
// until its four entries fill, then i_evt.ready drops.
`default_nettype none

module multi_click_and_motion_tracker_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    mcmt_evt_if.sink                                  i_evt,
    mcmt_res_if.source                                o_res,
    input  wire logic                                 i_cfg_we,
    input  wire logic [mcmt_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  wire logic [mcmt_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    mcmt_pkg::t_cfg r_cfg;
    logic           w_pop;
    logic           w_q_valid;
    mcmt_pkg::t_op  w_q_op;

    // Register file: unknown indexes drop the write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval   <= mcmt_pkg::INTERVAL_RESET;
            r_cfg.slop       <= mcmt_pkg::SLOP_RESET;
            r_cfg.max_clicks <= mcmt_pkg::MAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mcmt_pkg::CFG_IDX_INTERVAL:
                    r_cfg.interval <= i_cfg_data[mcmt_pkg::INTERVAL_BITS-1:0];
                mcmt_pkg::CFG_IDX_SLOP:
                    r_cfg.slop <= i_cfg_data[mcmt_pkg::SLOP_BITS-1:0];
                mcmt_pkg::CFG_IDX_MAX:
                    r_cfg.max_clicks <= i_cfg_data[mcmt_pkg::CLICK_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Front end: classify and queue events.
    mcmt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_evt     (i_evt),
        .i_pop     (w_pop),
        .o_q_valid (w_q_valid),
        .o_q_op    (w_q_op)
    );

    // Back end: update tracking state and drive the result register.
    mcmt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (w_q_valid),
        .i_q_op    (w_q_op),
        .o_pop     (w_pop),
        .o_res     (o_res)
    );

endmodule

`default_nettype wire
